/* hdl/ede_pkg.sv */
package ede_pkg;

    // operation codes carried in s_axis_tuser
    localparam logic [1:0] OP_TARGET = 2'd0;
    localparam logic [1:0] OP_SOURCE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam int SYM_W  = 8;
    localparam int DIST_W = 9;

    // token control that moves down the cell chain with each source or end item
    typedef struct packed {
        logic vld;
        logic last;
    } t_tok;

endpackage

/* hdl/ede_cell.sv */
module ede_cell
    import ede_pkg::*;
#(
    parameter int CW    = 9,
    parameter int INDEX = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [SYM_W-1:0] i_wr_sym,
    input  t_tok             i_tok,
    input  logic [SYM_W-1:0] i_sym,
    input  logic [CW-1:0]    i_left,
    input  logic [CW-1:0]    i_diag,
    output t_tok             o_tok,
    output logic [SYM_W-1:0] o_sym,
    output logic [CW-1:0]    o_left,
    output logic [CW-1:0]    o_diag
);

    logic [SYM_W-1:0] r_tsym;
    logic             r_loaded;
    logic [CW-1:0]    r_val;
    t_tok             r_tok;
    logic [SYM_W-1:0] r_sym;
    logic [CW-1:0]    r_left;
    logic [CW-1:0]    r_diag;

    logic [CW-1:0] n_cost;
    logic [CW-1:0] m_ul;
    logic [CW-1:0] m_all;

    always_comb begin
        m_ul  = (r_val < i_left) ? r_val : i_left;
        m_all = (m_ul < i_diag) ? m_ul : i_diag;
        if (r_tsym == i_sym) begin
            n_cost = i_diag;
        end else begin
            n_cost = m_all + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_val    <= CW'(INDEX);
            r_tok    <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_wr) begin
                r_loaded <= 1'b1;
            end
            if (i_tok.vld && i_tok.last) begin
                // end token: clear for the next pair
                r_loaded <= 1'b0;
                r_val    <= CW'(INDEX);
            end else if (i_tok.vld && r_loaded) begin
                r_val <= n_cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_tsym <= i_wr_sym;
        end
        r_sym <= i_sym;
        if (!r_loaded) begin
            // unloaded cells pass the boundary value through
            r_left <= i_left;
            r_diag <= i_diag;
        end else if (i_tok.last) begin
            r_left <= r_val;
            r_diag <= r_val;
        end else begin
            r_left <= n_cost;
            r_diag <= r_val;
        end
    end

    assign o_tok  = r_tok;
    assign o_sym  = r_sym;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

/* hdl/edit_distance_engine.sv */
// channel   dir  tdata               tuser          item
// s_axis    in   [7:0] symbol        [1:0] operation  target, source or end item
// m_axis    out  [8:0] distance      [0] overflow     one per end item
//
// target and source items are taken one per cycle while the input is not stalled; a
// source item enters the cell chain and moves one cell per cycle, so items overlap in
// the chain. an end item closes the pair: the input stalls while the end token
// crosses all MAX_LEN cells and its result is handed over.
// synchronous reset puts every cell at its initial cost at once, no sweep.
// a result waiting on m_axis stalls the input only after the next end item.
module edit_distance_engine
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [8:0] distance, rest zero
    output logic        m_axis_tuser    // [0] overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_tgt_len, n_tgt_len;
    logic [CW-1:0] r_src_cnt, n_src_cnt;
    logic          r_ovf, n_ovf;
    logic          r_end_ovf;
    logic          r_busy;
    logic          r_pend;
    logic [CW-1:0] r_pend_dist;
    logic          r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic          r_out_ovf;

    logic          acc;
    logic          wr_en;
    logic          end_acc;
    logic          pend_move;
    logic [CW+DIST_W-1:0] dist_ext;

    t_tok             w_tok  [0:MAX_LEN];
    logic [SYM_W-1:0] w_sym  [0:MAX_LEN];
    logic [CW-1:0]    w_left [0:MAX_LEN];
    logic [CW-1:0]    w_diag [0:MAX_LEN];

    assign s_axis_tready = !r_busy;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_tgt_len = r_tgt_len;
        n_src_cnt = r_src_cnt;
        n_ovf     = r_ovf;
        wr_en     = 1'b0;
        end_acc   = 1'b0;
        w_tok[0]  = '0;
        w_sym[0]  = s_axis_tdata;
        w_left[0] = r_src_cnt;
        w_diag[0] = r_src_cnt;
        if (acc) begin
            case (s_axis_tuser)
                OP_TARGET: begin
                    if (r_src_cnt == '0) begin
                        if (r_tgt_len < CW'(MAX_LEN)) begin
                            wr_en     = 1'b1;
                            n_tgt_len = r_tgt_len + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                OP_SOURCE: begin
                    if (r_src_cnt < CW'(MAX_LEN)) begin
                        w_tok[0].vld = 1'b1;
                        w_left[0]    = r_src_cnt + CW'(1);
                        n_src_cnt    = r_src_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_END: begin
                    // left value of the boundary column is the source count
                    w_tok[0].vld  = 1'b1;
                    w_tok[0].last = 1'b1;
                    end_acc       = 1'b1;
                    n_tgt_len     = '0;
                    n_src_cnt     = '0;
                    n_ovf         = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        ede_cell #(
            .CW    (CW),
            .INDEX (k + 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (wr_en && (r_tgt_len == CW'(k))),
            .i_wr_sym (s_axis_tdata),
            .i_tok    (w_tok[k]),
            .i_sym    (w_sym[k]),
            .i_left   (w_left[k]),
            .i_diag   (w_diag[k]),
            .o_tok    (w_tok[k+1]),
            .o_sym    (w_sym[k+1]),
            .o_left   (w_left[k+1]),
            .o_diag   (w_diag[k+1])
        );
    end

    assign pend_move = r_pend && (!r_out_valid || m_axis_tready);
    assign dist_ext  = {{DIST_W{1'b0}}, r_pend_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_len   <= '0;
            r_src_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tgt_len <= n_tgt_len;
            r_src_cnt <= n_src_cnt;
            r_ovf     <= n_ovf;
            if (end_acc) begin
                r_busy <= 1'b1;
            end else if (pend_move) begin
                r_busy <= 1'b0;
            end
            if (w_tok[MAX_LEN].vld && w_tok[MAX_LEN].last) begin
                r_pend <= 1'b1;
            end else if (pend_move) begin
                r_pend <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_acc) begin
            r_end_ovf <= r_ovf;
        end
        if (w_tok[MAX_LEN].vld && w_tok[MAX_LEN].last) begin
            r_pend_dist <= w_left[MAX_LEN];
        end
        if (pend_move) begin
            r_out_dist <= dist_ext[DIST_W-1:0];
            r_out_ovf  <= r_end_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - DIST_W){1'b0}}, r_out_dist};
    assign m_axis_tuser  = r_out_ovf;

    a_tok_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok[MAX_LEN].vld && w_tok[MAX_LEN].last) |-> (r_busy && !r_pend))
        else $error("end token left the chain outside a drain");

    a_src_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_cnt <= CW'(MAX_LEN)) && (r_tgt_len <= CW'(MAX_LEN)))
        else $error("pair counters beyond maximum length");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_acc |=> (r_tgt_len == '0 && r_src_cnt == '0 && !r_ovf && r_busy))
        else $error("end item did not clear the pair");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("pending result while input open");

endmodule
